// ----- rtl/core/slcan_line_parser_macros.svh -----
// assertion macros shared by the slcan line parser modules
`ifndef SLCAN_LINE_PARSER_MACROS_SVH
`define SLCAN_LINE_PARSER_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define SLCAN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slcan: same-cycle check failed");

// condition must hold in the cycle after the trigger
`define SLCAN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slcan: next-cycle check failed");

`endif

// ----- rtl/core/slcan_pkg.sv -----
// shared constants, types and character helpers of the slcan line parser
package slcan_pkg;

	localparam int LINE_DEPTH = 32;
	localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int POS_W      = 5;
	localparam int CHAR_W     = 7;
	localparam int NIB_W      = 4;
	localparam int NIB_N      = 16;
	localparam int ID_W       = 29;
	localparam int STD_ID_W   = 11;
	localparam int DLC_W      = 4;
	localparam int DATA_W     = 64;

	// last line position the decoder ever needs (extended data frame, eight bytes)
	localparam logic [POS_W-1:0] MAX_POS = 5'd25;
	localparam logic [DLC_W-1:0] DLC_MAX = 4'd8;
	localparam logic [POS_W-1:0] STD_DIGITS = 5'd3;
	localparam logic [POS_W-1:0] EXT_DIGITS = 5'd8;

	// raw byte codes
	localparam logic [7:0] BYTE_SPACE = 8'h20;
	localparam logic [7:0] BYTE_TILDE = 8'h7e;
	localparam logic [7:0] BYTE_CRET  = 8'h0d;
	localparam logic [7:0] BYTE_BKSP  = 8'h08;
	localparam logic [7:0] BYTE_DEL   = 8'h7f;

	// stored character codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_EIGHT = 7'h38;
	localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;
	localparam logic [CHAR_W-1:0] CH_UF    = 7'h46;
	localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;
	localparam logic [CHAR_W-1:0] CH_LF    = 7'h66;
	localparam logic [CHAR_W-1:0] CH_UP_ALPHA_OFS = 7'h37;
	localparam logic [CHAR_W-1:0] CH_LO_ALPHA_OFS = 7'h57;
	localparam logic [CHAR_W-1:0] CMD_EXT_DATA = 7'h54;
	localparam logic [CHAR_W-1:0] CMD_STD_DATA = 7'h74;
	localparam logic [CHAR_W-1:0] CMD_EXT_RTR  = 7'h52;
	localparam logic [CHAR_W-1:0] CMD_STD_RTR  = 7'h72;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_REJECT  = 2'd1,
		STAT_BAD_HEX = 2'd2
	} slcan_status_t;

	typedef enum logic [1:0] {
		BYTE_PRINT,
		BYTE_CR,
		BYTE_ERASE,
		BYTE_OTHER
	} slcan_class_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} slcan_state_t;

	// parse kick-off from the line store to the decoder
	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] len;
	} slcan_start_t;

	function automatic slcan_class_t byte_class(input logic [7:0] b);
		slcan_class_t cls;
		if (b >= BYTE_SPACE && b <= BYTE_TILDE) begin
			cls = BYTE_PRINT;
		end else if (b == BYTE_CRET) begin
			cls = BYTE_CR;
		end else if (b == BYTE_BKSP || b == BYTE_DEL) begin
			cls = BYTE_ERASE;
		end else begin
			cls = BYTE_OTHER;
		end
		return cls;
	endfunction

	function automatic logic hex_ok(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UF) ||
			(c >= CH_LA && c <= CH_LF);
	endfunction

	// nibble value of a hex digit, zero for anything else
	function automatic logic [NIB_W-1:0] hex_val(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = c - CH_UP_ALPHA_OFS;
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = c - CH_LO_ALPHA_OFS;
		end else begin
			d = '0;
		end
		return d[NIB_W-1:0];
	endfunction

endpackage

// ----- rtl/core/slcan_line_parser.sv -----
// slcan line parser top level: input word handshake, line store and frame decoder
//
// Printable, erase and other control words are taken one per cycle while in_stall
// is low and edit the line store in that cycle. A carriage return starts the
// decoder, which reads the line back through the store's single registered read
// port, one character per cycle, with in_stall high; a rejected command gives the
// shortest parse and an extended data frame with eight bytes (26 characters) the
// longest. The result word then sits in an output register, so new input words are
// taken while it waits; a parse that ends while that register is still full keeps
// in_stall high until the word is taken. The store has no reset or clearing pass;
// only characters below the fill count are ever used.

module slcan_line_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic                          extended_id,
	output logic                          remote_request,
	output logic [slcan_pkg::ID_W-1:0]    frame_id,
	output logic [slcan_pkg::DLC_W-1:0]   data_length,
	output logic [slcan_pkg::DATA_W-1:0]  payload
);
	import slcan_pkg::*;

	logic               busy;
	logic               accept;
	logic [ADDR_W-1:0]  rd_addr;
	logic [CHAR_W-1:0]  rd_data;
	slcan_start_t       start;

	// input is held off while a line is parsed and until its result is loaded
	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	slcan_line_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.start   (start)
	);

	slcan_frame_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.extended_id    (extended_id),
		.remote_request (remote_request),
		.frame_id       (frame_id),
		.data_length    (data_length),
		.payload        (payload)
	);

endmodule

// ----- rtl/core/slcan_line_store.sv -----
// line memory with fill count and line editing for the slcan parser
`include "slcan_line_parser_macros.svh"

module slcan_line_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [7:0]                    rx_byte,
	input  logic [slcan_pkg::ADDR_W-1:0]  rd_addr,
	output logic [slcan_pkg::CHAR_W-1:0]  rd_data,
	output slcan_pkg::slcan_start_t       start
);
	import slcan_pkg::*;

	logic [CHAR_W-1:0] mem [LINE_DEPTH];
	logic [CHAR_W-1:0] rd_data_q;
	logic [CNT_W-1:0]  fill_q;
	slcan_class_t      cls;
	logic              full;

	// classify incoming word
	always_comb begin
		cls  = byte_class(rx_byte);
		full = (fill_q == CNT_W'(LINE_DEPTH));
	end

	// fill count editing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			case (cls)
				BYTE_PRINT: fill_q <= full ? '0 : fill_q + 1'b1;
				BYTE_ERASE: begin
					if (fill_q != '0) begin
						fill_q <= fill_q - 1'b1;
					end
				end
				default:    fill_q <= '0;
			endcase
		end
	end

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (accept && cls == BYTE_PRINT && !full) begin
			mem[fill_q[ADDR_W-1:0]] <= rx_byte[CHAR_W-1:0];
		end
		rd_data_q <= mem[rd_addr];
	end

	// carriage return hands the line length to the decoder
	always_comb begin
		rd_data     = rd_data_q;
		start.start = accept && cls == BYTE_CR;
		start.len   = fill_q;
	end

	`SLCAN_ASSERT_SAME(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CNT_W'(LINE_DEPTH))

endmodule

// ----- rtl/core/slcan_frame_decode.sv -----
// sequential frame decoder: walks the stored line one character per cycle
`include "slcan_line_parser_macros.svh"

module slcan_frame_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slcan_pkg::slcan_start_t       start,
	output logic                          busy,
	output logic [slcan_pkg::ADDR_W-1:0]  rd_addr,
	input  logic [slcan_pkg::CHAR_W-1:0]  rd_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic                          extended_id,
	output logic                          remote_request,
	output logic [slcan_pkg::ID_W-1:0]    frame_id,
	output logic [slcan_pkg::DLC_W-1:0]   data_length,
	output logic [slcan_pkg::DATA_W-1:0]  payload
);
	import slcan_pkg::*;

	slcan_state_t state_q, state_n;
	logic [CNT_W-1:0] len_q;
	logic [POS_W-1:0] rd_pos_q;
	logic             vld_s1;
	logic [POS_W-1:0] pos_s1;

	// working registers
	logic                       ext_q, rtr_q, bad_q;
	logic [ID_W-1:0]            id_q;
	logic [DLC_W-1:0]           dlc_q;
	logic [NIB_W-1:0]           nib_q;
	logic [NIB_N-1:0][NIB_W-1:0] pay_q;
	slcan_status_t              stat_q;

	// next values
	logic                       ext_n, rtr_n, bad_n;
	logic [ID_W-1:0]            id_n;
	logic [DLC_W-1:0]           dlc_n;
	logic [NIB_W-1:0]           nib_n;
	logic [NIB_N-1:0][NIB_W-1:0] pay_n;
	slcan_status_t              fin_stat;
	logic                       fin;

	// output register
	logic                 out_valid_q;
	slcan_status_t        out_stat_q;
	logic                 out_ext_q, out_rtr_q;
	logic [ID_W-1:0]      out_id_q;
	logic [DLC_W-1:0]     out_dlc_q;
	logic [DATA_W-1:0]    out_pay_q;

	logic [CHAR_W-1:0] c;
	logic [CHAR_W-1:0] c_off;
	logic [NIB_W-1:0]  hv;
	logic              hok;
	logic [POS_W-1:0]  digits, dlc_pos, data_end;
	logic              load;

	// character at the position in stage 1, past the line end reads as nul
	always_comb begin
		c        = (CNT_W'(pos_s1) < len_q) ? rd_data : '0;
		c_off    = c - CH_ZERO;
		hv       = hex_val(c);
		hok      = hex_ok(c);
		digits   = ext_q ? EXT_DIGITS : STD_DIGITS;
		dlc_pos  = digits + 1'b1;
		data_end = dlc_pos + {dlc_q, 1'b0};
	end

	// per-character decode step
	always_comb begin
		ext_n    = ext_q;
		rtr_n    = rtr_q;
		bad_n    = bad_q;
		id_n     = id_q;
		dlc_n    = dlc_q;
		nib_n    = nib_q;
		pay_n    = pay_q;
		fin      = 1'b0;
		fin_stat = STAT_OK;
		if (vld_s1) begin
			if (pos_s1 == '0) begin
				ext_n = 1'b0;
				rtr_n = 1'b0;
				bad_n = 1'b0;
				id_n  = '0;
				dlc_n = '0;
				nib_n = '0;
				pay_n = '0;
				case (c)
					CMD_EXT_DATA: ext_n = 1'b1;
					CMD_STD_DATA: ext_n = 1'b0;
					CMD_EXT_RTR: begin
						ext_n = 1'b1;
						rtr_n = 1'b1;
					end
					CMD_STD_RTR:  rtr_n = 1'b1;
					default: begin
						fin      = 1'b1;
						fin_stat = STAT_REJECT;
					end
				endcase
			end else if (pos_s1 <= digits) begin
				// identifier digit
				id_n  = {id_q[ID_W-NIB_W-1:0], hv};
				bad_n = bad_q | ~hok;
				if (pos_s1 == POS_W'(1) && rtr_q && !ext_q && c > CH_NINE) begin
					fin      = 1'b1;
					fin_stat = STAT_REJECT;
				end
			end else if (pos_s1 == dlc_pos) begin
				// length digit
				if (ext_q && !rtr_q) begin
					if (bad_q || !hok || hv > DLC_MAX) begin
						fin      = 1'b1;
						fin_stat = STAT_REJECT;
					end else begin
						dlc_n = hv;
					end
				end else if (c < CH_ZERO || c > CH_EIGHT) begin
					fin      = 1'b1;
					fin_stat = STAT_REJECT;
				end else begin
					dlc_n = c_off[DLC_W-1:0];
				end
				if (!fin && (rtr_q || dlc_n == '0)) begin
					fin      = 1'b1;
					fin_stat = bad_q ? STAT_BAD_HEX : STAT_OK;
				end
			end else begin
				// data nibble, first nibble lands in the top of the payload
				pay_n[NIB_W'(NIB_N-1) - nib_q] = hv;
				bad_n = bad_q | ~hok;
				nib_n = nib_q + 1'b1;
				if (pos_s1 == data_end) begin
					fin      = 1'b1;
					fin_stat = bad_n ? STAT_BAD_HEX : STAT_OK;
				end
			end
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start.start) begin
					state_n = ST_RUN;
				end
			end
			ST_RUN: begin
				if (fin) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy    = (state_q != ST_IDLE);
		rd_addr = ADDR_W'(rd_pos_q);
		load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_pos_q <= '0;
			len_q    <= '0;
			vld_s1   <= 1'b0;
			pos_s1   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_IDLE && start.start) begin
				rd_pos_q <= '0;
				len_q    <= start.len;
			end else if (state_q == ST_RUN) begin
				rd_pos_q <= rd_pos_q + 1'b1;
			end
			vld_s1 <= (state_q == ST_RUN) && !fin;
			pos_s1 <= rd_pos_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		ext_q <= ext_n;
		rtr_q <= rtr_n;
		bad_q <= bad_n;
		id_q  <= id_n;
		dlc_q <= dlc_n;
		nib_q <= nib_n;
		pay_q <= pay_n;
		if (fin) begin
			stat_q <= fin_stat;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_stat_q <= stat_q;
			if (stat_q == STAT_OK) begin
				out_ext_q <= ext_q;
				out_rtr_q <= rtr_q;
				out_id_q  <= ext_q ? id_q : {{(ID_W-STD_ID_W){1'b0}}, id_q[STD_ID_W-1:0]};
				out_dlc_q <= dlc_q;
				out_pay_q <= pay_q;
			end else begin
				out_ext_q <= 1'b0;
				out_rtr_q <= 1'b0;
				out_id_q  <= '0;
				out_dlc_q <= '0;
				out_pay_q <= '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_stat_q;
	assign extended_id    = out_ext_q;
	assign remote_request = out_rtr_q;
	assign frame_id       = out_id_q;
	assign data_length    = out_dlc_q;
	assign payload        = out_pay_q;

	`SLCAN_ASSERT_NEXT(a_start_runs, clk, arst_n, start.start, state_q == ST_RUN)
	`SLCAN_ASSERT_SAME(a_pos_bound, clk, arst_n, vld_s1, pos_s1 <= MAX_POS)
	`SLCAN_ASSERT_SAME(a_reject_clean, clk, arst_n, out_valid_q && out_stat_q != STAT_OK, out_id_q == '0 && out_pay_q == '0 && out_dlc_q == '0)

endmodule
